### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Standalone header; concurrent properties use the clock and active-low reset given.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/gbe_pkg.sv
// Package for the gap buffer edit engine: command codes, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package gbe_pkg;

    localparam int CAPACITY_DEFAULT = 4096;
    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [3:0] {
        OP_INSERT   = 4'd0,
        OP_DEL_BACK = 4'd1,
        OP_DEL_FWD  = 4'd2,
        OP_LEFT     = 4'd3,
        OP_RIGHT    = 4'd4,
        OP_UP       = 4'd5,
        OP_DOWN     = 4'd6,
        OP_BOL      = 4'd7,
        OP_EOL      = 4'd8,
        OP_TOP      = 4'd9,
        OP_BOTTOM   = 4'd10,
        OP_DEL_LINE = 4'd11,
        OP_MOVE     = 4'd12,
        OP_READ     = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

### hdl/gap_buffer_edit_engine.sv
// Top level of the gap buffer edit engine: sequencer plus text store.
// Depends on gbe_pkg, gbe_ctrl, gbe_mem and assert_macros.svh.
//
// One command is accepted when start is high and busy is low; exactly one result follows,
// shown for one cycle with strobe high, and the receiver cannot stall it. Insert, delete,
// range errors and unused codes go from idle straight to the done state; read passes
// through a read-wait state first. Every byte the gap moves is read and then written back
// across the gap, and every byte a line scan inspects is read and then compared, both bound
// by the single read port of the text store, so line, move and delete-line commands take
// time in proportion to the distance covered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gap_buffer_edit_engine #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEFAULT,
    parameter int PW       = $clog2(CAPACITY + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [3:0]    op,
    input  logic [7:0]    ch,
    input  logic [PW-1:0] pos,
    output logic          strobe,
    output logic [7:0]    char_out,
    output logic [PW-1:0] text_length,
    output logic [PW-1:0] cursor,
    output logic [1:0]    status
);
    import gbe_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    gbe_ctrl #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .AW       (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .ch          (ch),
        .pos         (pos),
        .busy        (busy),
        .strobe      (strobe),
        .char_out    (char_out),
        .text_length (text_length),
        .cursor      (cursor),
        .status      (status),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    gbe_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_strobe_after_busy, clk, rst_n, strobe, $past(busy))
    `ASSERT_IMPLIES(a_cursor_in_text, clk, rst_n, strobe, cursor <= text_length)
    `ASSERT_IMPLIES(a_length_bound, clk, rst_n, strobe, text_length <= PW'(CAPACITY))
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, strobe, status <= ST_RANGE)

endmodule

### hdl/gbe_mem.sv
// Text store: single-port-write, single-port-read synchronous memory.
// Read data is registered; depends on nothing else.
`timescale 1ns / 1ps
module gbe_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_q [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_q[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/gbe_ctrl.sv
// Command sequencer: gap pointers, line scans, gap shifts and result registers.
// Depends on gbe_pkg; drives the text store in gbe_mem.
`timescale 1ns / 1ps
module gbe_ctrl #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEFAULT,
    parameter int PW       = $clog2(CAPACITY + 1),
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [3:0]    op,
    input  logic [7:0]    ch,
    input  logic [PW-1:0] pos,
    output logic          busy,
    output logic          strobe,
    output logic [7:0]    char_out,
    output logic [PW-1:0] text_length,
    output logic [PW-1:0] cursor,
    output logic [1:0]    status,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);
    import gbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SCAN_REQ,
        S_SCAN_CHK,
        S_DISPATCH,
        S_SHIFT,
        S_SHIFT_WL,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [3:0]    op_reg;
    logic [1:0]    step_reg;
    logic [PW-1:0] gs_reg;
    logic [PW-1:0] ge_reg;
    logic [PW-1:0] scan_p_reg;
    logic          scan_back_reg;
    logic [PW-1:0] a_reg;
    logic [PW-1:0] col_reg;
    logic [PW-1:0] target_reg;
    logic [PW-1:0] extra_reg;
    logic [7:0]    char_reg;
    logic [1:0]    status_reg;
    logic          strobe_reg;
    logic [7:0]    char_out_reg;
    logic [PW-1:0] length_out_reg;
    logic [PW-1:0] cursor_out_reg;
    logic [1:0]    status_out_reg;

    logic [PW-1:0] len;
    logic [PW-1:0] up_n;
    logic [PW-1:0] dn_n;
    logic [PW-1:0] up_target;
    logic [PW-1:0] dn_target;

    function automatic logic [AW-1:0] phys(input logic [PW-1:0] p,
                                           input logic [PW-1:0] gs,
                                           input logic [PW-1:0] ge);
        logic [PW-1:0] t;
        t = (p < gs) ? p : ge + (p - gs);
        return t[AW-1:0];
    endfunction

    assign len       = PW'(CAPACITY) - (ge_reg - gs_reg);
    assign up_n      = a_reg - 1'b1 - scan_p_reg;
    assign dn_n      = scan_p_reg - a_reg;
    assign up_target = scan_p_reg + ((col_reg < up_n) ? col_reg : up_n);
    assign dn_target = a_reg + ((col_reg < dn_n) ? col_reg : dn_n);

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign char_out    = char_out_reg;
    assign text_length = length_out_reg;
    assign cursor      = cursor_out_reg;
    assign status      = status_out_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = gs_reg[AW-1:0];
        mem_wdata = ch;
        mem_re    = 1'b0;
        mem_raddr = phys(pos, gs_reg, ge_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && op == OP_INSERT && gs_reg != ge_reg)
                begin
                    mem_we = 1'b1;
                end
                if (start && op == OP_READ && pos < len)
                begin
                    mem_re = 1'b1;
                end
            end
            S_SCAN_REQ:
            begin
                if (scan_back_reg)
                begin
                    mem_re    = (scan_p_reg != '0);
                    mem_raddr = phys(scan_p_reg - 1'b1, gs_reg, ge_reg);
                end
                else
                begin
                    mem_re    = (scan_p_reg < len);
                    mem_raddr = phys(scan_p_reg, gs_reg, ge_reg);
                end
            end
            S_SHIFT:
            begin
                if (target_reg < gs_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = gs_reg[AW-1:0] - 1'b1;
                end
                else if (target_reg > gs_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ge_reg[AW-1:0];
                end
            end
            S_SHIFT_WL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ge_reg[AW-1:0] - 1'b1;
                mem_wdata = mem_rdata;
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = gs_reg[AW-1:0];
                mem_wdata = mem_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gs_reg         <= '0;
            ge_reg         <= PW'(CAPACITY);
            strobe_reg     <= 1'b0;
            op_reg         <= '0;
            step_reg       <= '0;
            scan_p_reg     <= '0;
            scan_back_reg  <= 1'b0;
            a_reg          <= '0;
            col_reg        <= '0;
            target_reg     <= '0;
            extra_reg      <= '0;
            char_reg       <= '0;
            status_reg     <= ST_OK;
            char_out_reg   <= '0;
            length_out_reg <= '0;
            cursor_out_reg <= '0;
            status_out_reg <= ST_OK;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= op;
                        status_reg <= ST_OK;
                        char_reg   <= '0;
                        extra_reg  <= '0;
                        step_reg   <= '0;
                        state_reg  <= S_DONE;
                        unique case (op)
                            OP_INSERT:
                            begin
                                if (gs_reg == ge_reg)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    gs_reg <= gs_reg + 1'b1;
                                end
                            end
                            OP_DEL_BACK:
                            begin
                                if (gs_reg != '0)
                                begin
                                    gs_reg <= gs_reg - 1'b1;
                                end
                            end
                            OP_DEL_FWD:
                            begin
                                if (ge_reg != PW'(CAPACITY))
                                begin
                                    ge_reg <= ge_reg + 1'b1;
                                end
                            end
                            OP_LEFT:
                            begin
                                if (gs_reg != '0)
                                begin
                                    target_reg <= gs_reg - 1'b1;
                                    state_reg  <= S_SHIFT;
                                end
                            end
                            OP_RIGHT:
                            begin
                                if (gs_reg < len)
                                begin
                                    target_reg <= gs_reg + 1'b1;
                                    state_reg  <= S_SHIFT;
                                end
                            end
                            OP_UP, OP_DOWN, OP_BOL:
                            begin
                                scan_p_reg    <= gs_reg;
                                scan_back_reg <= 1'b1;
                                state_reg     <= S_SCAN_REQ;
                            end
                            OP_DEL_LINE:
                            begin
                                if (len != '0)
                                begin
                                    scan_p_reg    <= gs_reg;
                                    scan_back_reg <= 1'b1;
                                    state_reg     <= S_SCAN_REQ;
                                end
                            end
                            OP_EOL:
                            begin
                                scan_p_reg    <= gs_reg;
                                scan_back_reg <= 1'b0;
                                state_reg     <= S_SCAN_REQ;
                            end
                            OP_TOP:
                            begin
                                target_reg <= '0;
                                state_reg  <= S_SHIFT;
                            end
                            OP_BOTTOM:
                            begin
                                target_reg <= len;
                                state_reg  <= S_SHIFT;
                            end
                            OP_MOVE:
                            begin
                                if (pos > len)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    target_reg <= pos;
                                    state_reg  <= S_SHIFT;
                                end
                            end
                            OP_READ:
                            begin
                                if (pos >= len)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    state_reg <= S_READ_WAIT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ_WAIT:
                begin
                    char_reg  <= mem_rdata;
                    state_reg <= S_DONE;
                end
                S_SCAN_REQ:
                begin
                    if (scan_back_reg ? (scan_p_reg == '0) : (scan_p_reg >= len))
                    begin
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (mem_rdata == NEWLINE)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        scan_p_reg <= scan_back_reg ? scan_p_reg - 1'b1 : scan_p_reg + 1'b1;
                        state_reg  <= S_SCAN_REQ;
                    end
                end
                S_DISPATCH:
                begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= S_SHIFT;
                    target_reg <= scan_p_reg;
                    unique case (op_reg)
                        OP_UP:
                        begin
                            if (step_reg == 2'd0)
                            begin
                                if (scan_p_reg == '0)
                                begin
                                    target_reg <= gs_reg;
                                end
                                else
                                begin
                                    a_reg         <= scan_p_reg;
                                    col_reg       <= gs_reg - scan_p_reg;
                                    scan_p_reg    <= scan_p_reg - 1'b1;
                                    scan_back_reg <= 1'b1;
                                    state_reg     <= S_SCAN_REQ;
                                end
                            end
                            else
                            begin
                                target_reg <= up_target;
                            end
                        end
                        OP_DOWN:
                        begin
                            if (step_reg == 2'd0)
                            begin
                                col_reg       <= gs_reg - scan_p_reg;
                                scan_p_reg    <= gs_reg;
                                scan_back_reg <= 1'b0;
                                state_reg     <= S_SCAN_REQ;
                            end
                            else if (step_reg == 2'd1)
                            begin
                                if (scan_p_reg < len)
                                begin
                                    a_reg         <= scan_p_reg + 1'b1;
                                    scan_p_reg    <= scan_p_reg + 1'b1;
                                    scan_back_reg <= 1'b0;
                                    state_reg     <= S_SCAN_REQ;
                                end
                            end
                            else
                            begin
                                target_reg <= dn_target;
                            end
                        end
                        OP_DEL_LINE:
                        begin
                            if (step_reg == 2'd0)
                            begin
                                a_reg         <= scan_p_reg;
                                scan_p_reg    <= gs_reg;
                                scan_back_reg <= 1'b0;
                                state_reg     <= S_SCAN_REQ;
                            end
                            else
                            begin
                                target_reg <= a_reg;
                                extra_reg  <= ((scan_p_reg < len) ? scan_p_reg + 1'b1
                                                                  : scan_p_reg) - a_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SHIFT:
                begin
                    if (target_reg < gs_reg)
                    begin
                        state_reg <= S_SHIFT_WL;
                    end
                    else if (target_reg > gs_reg)
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                    else
                    begin
                        ge_reg    <= ge_reg + extra_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_SHIFT_WL:
                begin
                    gs_reg    <= gs_reg - 1'b1;
                    ge_reg    <= ge_reg - 1'b1;
                    state_reg <= S_SHIFT;
                end
                S_SHIFT_WR:
                begin
                    gs_reg    <= gs_reg + 1'b1;
                    ge_reg    <= ge_reg + 1'b1;
                    state_reg <= S_SHIFT;
                end
                S_DONE:
                begin
                    strobe_reg     <= 1'b1;
                    char_out_reg   <= char_reg;
                    length_out_reg <= len;
                    cursor_out_reg <= gs_reg;
                    status_out_reg <= status_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/sv/tb_top.sv
// Testbench for gap_buffer_edit_engine: directed and random edit commands.
// A behavioral text model predicts every result; depends on gbe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
    import gbe_pkg::*;

    localparam int CAP = CAPACITY_DEFAULT;
    localparam int PW = $clog2(CAP + 1);
    localparam int IDLE_LIMIT = 16 * CAP + 2000;

    typedef struct packed {
        logic [7:0]    rd;
        logic [PW-1:0] len;
        logic [PW-1:0] cur;
        logic [1:0]    st;
    } edit_result_t;

    class edit_scoreboard;
        byte unsigned  text[$];
        int            cursor_pos;
        edit_result_t  pending[$];
        int            errors;
        int            checked;

        function new();
            cursor_pos = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int line_head(int p);
            while (p > 0 && text[p - 1] != NEWLINE)
                p--;
            return p;
        endfunction

        function int line_tail(int p);
            while (p < text.size() && text[p] != NEWLINE)
                p++;
            return p;
        endfunction

        function void note_command(logic [3:0] op, logic [7:0] ch, logic [PW-1:0] pos);
            edit_result_t r;
            int a;
            int b;
            int col;
            int n;
            int len;
            len = text.size();
            r.rd = 8'd0;
            r.st = ST_OK;
            case (op)
                OP_INSERT:
                    if (len == CAP)
                        r.st = ST_FULL;
                    else
                    begin
                        text.insert(cursor_pos, ch);
                        cursor_pos++;
                    end
                OP_DEL_BACK:
                    if (cursor_pos > 0)
                    begin
                        text.delete(cursor_pos - 1);
                        cursor_pos--;
                    end
                OP_DEL_FWD:
                    if (cursor_pos < len)
                        text.delete(cursor_pos);
                OP_LEFT:
                    if (cursor_pos > 0)
                        cursor_pos--;
                OP_RIGHT:
                    if (cursor_pos < len)
                        cursor_pos++;
                OP_UP:
                begin
                    a = line_head(cursor_pos);
                    if (a > 0)
                    begin
                        col = cursor_pos - a;
                        b = line_head(a - 1);
                        n = a - 1 - b;
                        cursor_pos = b + (col < n ? col : n);
                    end
                end
                OP_DOWN:
                begin
                    a = line_head(cursor_pos);
                    col = cursor_pos - a;
                    b = line_tail(cursor_pos);
                    if (b >= len)
                        cursor_pos = b;
                    else
                    begin
                        n = line_tail(b + 1) - (b + 1);
                        cursor_pos = b + 1 + (col < n ? col : n);
                    end
                end
                OP_BOL:
                    cursor_pos = line_head(cursor_pos);
                OP_EOL:
                    cursor_pos = line_tail(cursor_pos);
                OP_TOP:
                    cursor_pos = 0;
                OP_BOTTOM:
                    cursor_pos = len;
                OP_DEL_LINE:
                    if (len > 0)
                    begin
                        a = line_head(cursor_pos);
                        b = line_tail(cursor_pos);
                        if (b < len)
                            b++;
                        for (int i = a; i < b; i++)
                            text.delete(a);
                        cursor_pos = a;
                    end
                OP_MOVE:
                    if (pos > len)
                        r.st = ST_RANGE;
                    else
                        cursor_pos = pos;
                OP_READ:
                    if (pos >= len)
                        r.st = ST_RANGE;
                    else
                        r.rd = text[pos];
                default:
                    ;
            endcase
            r.len = PW'(text.size());
            r.cur = PW'(cursor_pos);
            pending.push_back(r);
        endfunction

        function void check_result(edit_result_t got);
            edit_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no command pending: %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.rd !== exp.rd)
            begin
                $display("%0t: char_out expected %0h actual %0h", $time, exp.rd, got.rd);
                errors++;
            end
            if (got.len !== exp.len)
            begin
                $display("%0t: text_length expected %0d actual %0d", $time, exp.len, got.len);
                errors++;
            end
            if (got.cur !== exp.cur)
            begin
                $display("%0t: cursor expected %0d actual %0d", $time, exp.cur, got.cur);
                errors++;
            end
            if (got.st !== exp.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [3:0]    op;
    logic [7:0]    ch;
    logic [PW-1:0] pos;
    logic          strobe;
    logic [7:0]    char_out;
    logic [PW-1:0] text_length;
    logic [PW-1:0] cursor;
    logic [1:0]    status;

    edit_scoreboard sb;
    int idle_cycles;
    int sent;

    gap_buffer_edit_engine u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .ch(ch), .pos(pos), .strobe(strobe),
        .char_out(char_out), .text_length(text_length),
        .cursor(cursor), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(op, ch, pos);
            if (strobe)
                sb.check_result({char_out, text_length, cursor, status});
            if ((start && !busy) || strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3));
        repeat (n) @(negedge clk);
    endtask

    task automatic send_command(logic [3:0] o, logic [7:0] c, logic [PW-1:0] p);
        start <= 1'b1;
        op <= o;
        ch <= c;
        pos <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
        if ($urandom_range(0, 2) != 0)
        begin
            start <= 1'b0;
            op <= 4'($urandom);
            ch <= 8'($urandom);
            pos <= PW'($urandom);
            @(negedge clk);
            idle_gap();
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return NEWLINE;
        else if (k < 5)
            return 8'($urandom);
        else
            return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic logic [PW-1:0] rand_pos();
        int len;
        len = sb.text.size();
        case ($urandom_range(0, 5))
            0: return PW'(len);
            1: return PW'(len + 1);
            2: return PW'($urandom);
            default: return (len == 0) ? '0 : PW'($urandom_range(0, len - 1));
        endcase
    endfunction

    task automatic random_command();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35)
            send_command(OP_INSERT, rand_char(), PW'($urandom));
        else if (k < 97)
            send_command(4'($urandom_range(OP_DEL_BACK, OP_READ)), 8'($urandom), rand_pos());
        else
            send_command(4'($urandom_range(14, 15)), 8'($urandom), PW'($urandom));
    endtask

    initial
    begin
        sb = new();
        idle_cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_TOP;
        ch = 8'd0;
        pos = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_command(OP_DEL_BACK, 8'd0, '0);
        send_command(OP_DEL_FWD, 8'd0, '0);
        send_command(OP_DEL_LINE, 8'd0, '0);
        send_command(OP_READ, 8'd0, '0);
        send_command(OP_MOVE, 8'd0, 13'd1);
        send_command(OP_MOVE, 8'd0, '1);
        send_command(OP_INSERT, 8'hFF, '0);
        send_command(OP_INSERT, NEWLINE, '0);
        send_command(OP_INSERT, 8'h00, '0);
        send_command(OP_INSERT, 8'h55, '0);
        send_command(OP_INSERT, NEWLINE, '0);
        send_command(OP_INSERT, 8'hAA, '0);
        send_command(OP_UP, 8'd0, '0);
        send_command(OP_UP, 8'd0, '0);
        send_command(OP_UP, 8'd0, '0);
        send_command(OP_DOWN, 8'd0, '0);
        send_command(OP_DOWN, 8'd0, '0);
        send_command(OP_DOWN, 8'd0, '0);
        send_command(OP_LEFT, 8'd0, '0);
        send_command(OP_BOL, 8'd0, '0);
        send_command(OP_EOL, 8'd0, '0);
        send_command(OP_TOP, 8'd0, '0);
        send_command(OP_READ, 8'd0, 13'd0);
        send_command(OP_BOTTOM, 8'd0, '0);
        send_command(OP_RIGHT, 8'd0, '0);
        drain();

        repeat (1275)
        begin
            if (sb.text.size() > 300)
                send_command(OP_DEL_LINE, 8'd0, '0);
            else
                random_command();
            if ($urandom_range(0, 199) == 0)
                drain();
        end
        drain();
        repeat (50) @(negedge clk);

        $display("Ran %0d commands, %0d results checked: edits, line moves and range errors.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### gap_buffer_edit_engine.f
+incdir+hdl
hdl/gbe_pkg.sv
hdl/gbe_mem.sv
hdl/gbe_ctrl.sv
hdl/gap_buffer_edit_engine.sv
tb/sv/tb_top.sv
